/* src/ske_pkg.sv */
// ske_pkg: shared constants for the sph kernel evaluator
// used by ske_ratio_sqrt, ske_hdiv and sph_kernel_eval_core; no dependencies
package ske_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;

    // radius divider datapath
    localparam int V_W     = 63;
    localparam int H_W     = 31;
    localparam int OVF_SH  = 63 - FRAC_BITS;
    localparam int CMP_W   = V_W + H_W + 1;
    localparam int HD_LAT  = V_W + 1;

    // ratio / root unit
    localparam int DIV_STG   = 64;
    localparam int SQ_STG    = 32;
    localparam int RATIO_LAT = DIV_STG + SQ_STG;

    localparam logic [31:0] ONE31   = 32'h8000_0000;
    localparam logic [63:0] PI_Q28  = 64'd843314857;
    localparam logic [31:0] K_POLY6 = 32'(((64'd315 << 50) + PI_Q28 / 2) / PI_Q28);
    localparam logic [31:0] K_SPIKY = 32'(((64'd45 << 56) + PI_Q28 / 2) / PI_Q28);
    localparam logic [31:0] K_CUB_W = 32'(((64'd8 << 56) + PI_Q28 / 2) / PI_Q28);
    localparam logic [31:0] K_CUB_G = 32'(((64'd48 << 56) + PI_Q28 / 2) / PI_Q28);
    localparam logic [63:0] EPS2_THR = 64'd281 >> (48 - 2 * FRAC_BITS);

    localparam logic [WORD_BITS-2:0] POS_LIM = {(WORD_BITS-1){1'b1}};
    localparam logic [WORD_BITS-1:0] NEG_LIM = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        CFG_KERNEL_MODE      = 2'd0,
        CFG_SMOOTHING_RADIUS = 2'd1
    } t_cfg_idx;

endpackage

/* src/sph_kernel_eval_core.sv */
// sph_kernel_eval_core: top level of the sph kernel evaluator (poly6 / spiky / cubic spline)
// depends on ske_pkg, ske_ratio_sqrt, ske_hdiv
//
// Fully pipelined: one offset beat is taken every cycle while the output is not stalled, and
// its result beat passes 3 input/square/sum stages, 96 stages of the ratio divider and square root
// unit, 4 shape and constant multiply stages, 4 radius divisions of 64 stages each, and the
// output register. The length is set by the bit-serial stages of the dividers and roots.
// When the output beat is not taken the whole pipeline holds, so o_in_ready is low exactly
// while a result waits and the consumer stalls. Configuration must only be written while no
// beat is in flight.
module sph_kernel_eval_core
    import ske_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [31:0] i_dx,
    input  logic [31:0] i_dy,
    input  logic [31:0] i_dz,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [30:0] o_weight,
    output logic [31:0] o_grad_x,
    output logic [31:0] o_grad_y,
    output logic [31:0] o_grad_z,
    output logic        o_saturated,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_wdata
);

    localparam int SB_LEN   = 4 + 4 * HD_LAT;
    localparam int SB_STEP4 = 3 + 3 * HD_LAT;
    localparam int MAG_W    = V_W - (31 - FRAC_BITS);

    typedef struct packed {
        logic       vld;
        logic       cmd;
        logic [2:0] neg;
        logic [2:0] nz;
        logic [2:0] dir_one;
        logic       in_sup;
        logic       inner;
        logic       live;
    } t_side;

    typedef enum logic [1:0] {
        SHP_M2,
        SHP_2M2,
        SHP_ONE_M6
    } t_shp;

    function automatic logic [32:0] mul31(input logic [33:0] a, input logic [33:0] b);
        logic [67:0] p;
        p = {34'd0, a} * {34'd0, b};
        return p[63:31];
    endfunction

    logic           en;
    logic           r_mode;
    logic [H_W-1:0] r_h;

    // front stages
    logic        r_p0_vld, r_p0_cmd;
    logic [31:0] r_p0_mag [3];
    logic [2:0]  r_p0_neg, r_p0_nz;
    logic        r_p1_vld, r_p1_cmd;
    logic [62:0] r_p1_sq [3];
    logic [61:0] r_p1_h2;
    logic [2:0]  r_p1_neg, r_p1_nz;
    logic        r_p2_vld, r_p2_cmd;
    logic [62:0] r_p2_sq [3];
    logic [63:0] r_p2_r2;
    logic [61:0] r_p2_h2;
    logic [2:0]  r_p2_neg, r_p2_nz;
    logic [31:0] raw [3];
    t_side       side_p2;

    t_side r_sa [RATIO_LAT];
    t_side r_sb [SB_LEN];

    logic [31:0] root_u;
    logic [30:0] u_hi;
    logic [31:0] root_d [3];

    // shape stages
    logic [32:0] r_t1, r_c, r_m2;
    t_shp        r_sel_a, r_sel_b;
    logic [31:0] r_da [3];
    logic [31:0] r_db [3];
    logic [32:0] r_p [3];
    logic [35:0] r_vv [3];
    logic [31:0] q_a, om_a, ou_a;
    logic [33:0] b_cg;
    logic [32:0] n_a, n_b, n_c;
    t_shp        n_sel;
    logic [31:0] n_d [3];
    logic [33:0] shape;
    logic [35:0] m6;
    logic [31:0] k_sel;
    logic [64:0] kp [3];

    logic [V_W-1:0] w_v   [3][5];
    logic           w_ovf [3][5];
    logic [H_W-1:0] div4;

    logic [30:0] n_weight;
    logic [31:0] n_grad [3];
    logic        n_sat;
    logic        r_out_valid;
    logic [30:0] r_weight;
    logic [31:0] r_grad [3];
    logic        r_sat;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_h    <= H_W'(65536);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KERNEL_MODE:      r_mode <= i_cfg_wdata[0];
                CFG_SMOOTHING_RADIUS: r_h    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign raw[0] = i_dx;
    assign raw[1] = i_dy;
    assign raw[2] = i_dz;

    // magnitudes, squares, sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_vld <= 1'b0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else if (en) begin
            r_p0_vld <= i_in_valid;
            r_p1_vld <= r_p0_vld;
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0_cmd <= i_cmd;
            for (int i = 0; i < 3; i++) begin
                r_p0_mag[i] <= raw[i][31] ? (~raw[i] + 32'd1) : raw[i];
                r_p0_neg[i] <= raw[i][31];
                r_p0_nz[i]  <= (raw[i] != 32'd0);
                r_p1_sq[i]  <= {31'd0, r_p0_mag[i]} * {31'd0, r_p0_mag[i]};
                r_p2_sq[i]  <= r_p1_sq[i];
            end
            r_p1_h2  <= {31'd0, r_h} * {31'd0, r_h};
            r_p1_cmd <= r_p0_cmd;
            r_p1_neg <= r_p0_neg;
            r_p1_nz  <= r_p0_nz;
            r_p2_r2  <= {1'b0, r_p1_sq[0]} + {1'b0, r_p1_sq[1]} + {1'b0, r_p1_sq[2]};
            r_p2_h2  <= r_p1_h2;
            r_p2_cmd <= r_p1_cmd;
            r_p2_neg <= r_p1_neg;
            r_p2_nz  <= r_p1_nz;
        end
    end

    always_comb begin
        side_p2.vld    = r_p2_vld;
        side_p2.cmd    = r_p2_cmd;
        side_p2.neg    = r_p2_neg;
        side_p2.nz     = r_p2_nz;
        side_p2.in_sup = r_p2_r2 < {2'b00, r_p2_h2};
        side_p2.inner  = {r_p2_r2, 2'b00} <= {4'd0, r_p2_h2};
        side_p2.live   = r_mode ? (r_p2_r2 > EPS2_THR) : (r_p2_r2 != 64'd0);
        for (int i = 0; i < 3; i++) begin
            side_p2.dir_one[i] = {1'b0, r_p2_sq[i]} >= r_p2_r2;
        end
    end

    // control sideband that runs alongside the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RATIO_LAT; k++) begin
                r_sa[k] <= '0;
            end
            for (int k = 0; k < SB_LEN; k++) begin
                r_sb[k] <= '0;
            end
        end else if (en) begin
            r_sa[0] <= side_p2;
            for (int k = 1; k < RATIO_LAT; k++) begin
                r_sa[k] <= r_sa[k-1];
            end
            r_sb[0] <= r_sa[RATIO_LAT-1];
            for (int k = 1; k < SB_LEN; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // q and u from r2 / h2, direction cosines from c^2 / r2
    ske_ratio_sqrt u_ratio_u (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_num      (r_p2_r2),
        .i_den      ({2'b00, r_p2_h2}),
        .o_root     (root_u),
        .o_ratio_hi (u_hi)
    );

    for (genvar g = 0; g < 3; g++) begin : g_dir
        ske_ratio_sqrt u_ratio_d (
            .i_clk      (i_clk),
            .i_en       (en),
            .i_num      ({1'b0, r_p2_sq[g]}),
            .i_den      (r_p2_r2),
            .o_root     (root_d[g]),
            .o_ratio_hi ()
        );
    end

    // shape operand selection
    always_comb begin
        t_side s;
        s     = r_sa[RATIO_LAT-1];
        q_a   = {1'b0, root_u[31:1]};
        om_a  = ONE31 - q_a;
        ou_a  = ONE31 - {1'b0, u_hi};
        b_cg  = 34'(2 * {2'b00, ONE31}) - 34'(3 * {2'b00, q_a});
        n_a   = {1'b0, om_a};
        n_b   = {1'b0, om_a};
        n_c   = {1'b0, ONE31};
        n_sel = SHP_M2;
        if (!s.cmd) begin
            if (!r_mode) begin
                n_a = {1'b0, ou_a};
                n_b = {1'b0, ou_a};
                n_c = {1'b0, ou_a};
            end else if (s.inner) begin
                n_a   = {1'b0, q_a};
                n_b   = {1'b0, q_a};
                n_c   = {1'b0, om_a};
                n_sel = SHP_ONE_M6;
            end else begin
                n_c   = {1'b0, om_a};
                n_sel = SHP_2M2;
            end
        end else if (r_mode && s.inner) begin
            n_a = {1'b0, q_a};
            n_b = b_cg[32:0];
        end
        for (int i = 0; i < 3; i++) begin
            n_d[i] = (!s.cmd || s.dir_one[i]) ? ONE31 : {1'b0, root_d[i][31:1]};
        end
    end

    always_comb begin
        m6 = 36'(6 * {3'b000, r_m2});
        case (r_sel_b)
            SHP_2M2:    shape = {r_m2, 1'b0};
            SHP_ONE_M6: shape = {2'b00, ONE31} - m6[33:0];
            default:    shape = {1'b0, r_m2};
        endcase
        if (r_sb[2].cmd) begin
            k_sel = r_mode ? K_CUB_G : K_SPIKY;
        end else begin
            k_sel = r_mode ? K_CUB_W : K_POLY6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1    <= mul31({1'b0, n_a}, {1'b0, n_b});
            r_c     <= n_c;
            r_sel_a <= n_sel;
            r_m2    <= mul31({1'b0, r_t1}, {1'b0, r_c});
            r_sel_b <= r_sel_a;
            for (int i = 0; i < 3; i++) begin
                r_da[i] <= n_d[i];
                r_db[i] <= r_da[i];
                r_p[i]  <= mul31(shape, {2'b00, r_db[i]});
                r_vv[i] <= kp[i][63:28];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            kp[i] = {33'd0, k_sel} * {32'd0, r_p[i]};
        end
    end

    // 4 radius divisions per lane; weights pass the last one through a divide by one
    assign div4 = r_sb[SB_STEP4].cmd ? r_h : H_W'(1 << FRAC_BITS);

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign w_v[l][0]   = {{(V_W-36){1'b0}}, r_vv[l]};
        assign w_ovf[l][0] = 1'b0;
        for (genvar st = 0; st < 4; st++) begin : g_step
            ske_hdiv u_hdiv (
                .i_clk (i_clk),
                .i_en  (en),
                .i_v   (w_v[l][st]),
                .i_ovf (w_ovf[l][st]),
                .i_div ((st == 3) ? div4 : r_h),
                .o_v   (w_v[l][st+1]),
                .o_ovf (w_ovf[l][st+1])
            );
        end
    end

    // clamp and sign
    always_comb begin
        t_side            s;
        logic [MAG_W-1:0] mag;
        logic             big;
        logic             act;
        s        = r_sb[SB_LEN-1];
        n_sat    = 1'b0;
        n_weight = '0;
        mag      = w_v[0][4][V_W-1:31-FRAC_BITS];
        big      = w_ovf[0][4] || (mag > MAG_W'(POS_LIM));
        if (s.in_sup && !s.cmd) begin
            n_weight = big ? POS_LIM : mag[30:0];
            n_sat    = big;
        end
        for (int i = 0; i < 3; i++) begin
            n_grad[i] = '0;
            mag       = w_v[i][4][V_W-1:31-FRAC_BITS];
            act       = s.in_sup && s.cmd && s.live && s.nz[i];
            if (s.neg[i]) begin
                big = w_ovf[i][4] || (mag > MAG_W'(POS_LIM));
                if (act) begin
                    n_grad[i] = big ? {1'b0, POS_LIM} : mag[31:0];
                end
            end else begin
                big = w_ovf[i][4] || (mag > MAG_W'(NEG_LIM));
                if (act) begin
                    n_grad[i] = 32'd0 - (big ? NEG_LIM : mag[31:0]);
                end
            end
            if (act && big) begin
                n_sat = 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_sb[SB_LEN-1].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_weight <= n_weight;
            r_grad   <= n_grad;
            r_sat    <= n_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_weight    = r_weight;
    assign o_grad_x    = r_grad[0];
    assign o_grad_y    = r_grad[1];
    assign o_grad_z    = r_grad[2];
    assign o_saturated = r_sat;

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_weight == '0) ||
                        (o_grad_x == '0 && o_grad_y == '0 && o_grad_z == '0))
        else $error("weight and gradient both nonzero");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_weight == POS_LIM) ||
            (o_grad_x == {1'b0, POS_LIM}) || (o_grad_x == NEG_LIM) ||
            (o_grad_y == {1'b0, POS_LIM}) || (o_grad_y == NEG_LIM) ||
            (o_grad_z == {1'b0, POS_LIM}) || (o_grad_z == NEG_LIM))
        else $error("saturation flag without a clamped result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

endmodule

/* src/ske_ratio_sqrt.sv */
// ske_ratio_sqrt: pipelined floor(sqrt(floor(num * 2^64 / den))), one bit per stage
// depends on ske_pkg
module ske_ratio_sqrt
    import ske_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic [31:0] o_root,
    output logic [30:0] o_ratio_hi
);

    logic [63:0] r_rem [DIV_STG];
    logic [63:0] r_quo [DIV_STG];
    logic [63:0] r_den [DIV_STG];
    logic [63:0] n_rem [DIV_STG];
    logic [63:0] n_quo [DIV_STG];
    logic [63:0] n_den [DIV_STG];
    logic [63:0] r_x   [SQ_STG];
    logic [63:0] r_rt  [SQ_STG];
    logic [30:0] r_hi  [SQ_STG];
    logic [63:0] n_x   [SQ_STG];
    logic [63:0] n_rt  [SQ_STG];
    logic [30:0] n_hi  [SQ_STG];

    function automatic logic [64:0] div_bit(input logic [63:0] rem, input logic [63:0] den);
        logic [63:0] rs;
        rs = {rem[62:0], 1'b0};
        if (rs >= den) begin
            return {rs - den, 1'b1};
        end
        return {rs, 1'b0};
    endfunction

    function automatic logic [127:0] sq_bit(input logic [63:0] x, input logic [63:0] rt,
                                            input logic [63:0] b);
        logic [63:0] tr;
        tr = rt + b;
        if (x >= tr) begin
            return {x - tr, (rt >> 1) + b};
        end
        return {x, rt >> 1};
    endfunction

    always_comb begin
        logic [64:0]  t_d;
        logic [127:0] t_s;
        t_d      = div_bit(i_num, i_den);
        n_rem[0] = t_d[64:1];
        n_quo[0] = {63'd0, t_d[0]};
        n_den[0] = i_den;
        for (int k = 1; k < DIV_STG; k++) begin
            t_d      = div_bit(r_rem[k-1], r_den[k-1]);
            n_rem[k] = t_d[64:1];
            n_quo[k] = {r_quo[k-1][62:0], t_d[0]};
            n_den[k] = r_den[k-1];
        end
        t_s     = sq_bit(r_quo[DIV_STG-1], 64'd0, 64'd1 << 62);
        n_x[0]  = t_s[127:64];
        n_rt[0] = t_s[63:0];
        n_hi[0] = r_quo[DIV_STG-1][63:33];
        for (int j = 1; j < SQ_STG; j++) begin
            t_s     = sq_bit(r_x[j-1], r_rt[j-1], 64'd1 << (62 - 2 * j));
            n_x[j]  = t_s[127:64];
            n_rt[j] = t_s[63:0];
            n_hi[j] = r_hi[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STG; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= n_den[k];
            end
            for (int j = 0; j < SQ_STG; j++) begin
                r_x[j]  <= n_x[j];
                r_rt[j] <= n_rt[j];
                r_hi[j] <= n_hi[j];
            end
        end
    end

    assign o_root     = r_rt[SQ_STG-1][31:0];
    assign o_ratio_hi = r_hi[SQ_STG-1];

endmodule

/* src/ske_hdiv.sv */
// ske_hdiv: pipelined floor(v * 2^FRAC_BITS / h) with overflow flag, one bit per stage
// depends on ske_pkg
module ske_hdiv
    import ske_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [V_W-1:0] i_v,
    input  logic           i_ovf,
    input  logic [H_W-1:0] i_div,
    output logic [V_W-1:0] o_v,
    output logic           o_ovf
);

    logic [H_W-1:0] r_rem [HD_LAT];
    logic [V_W-1:0] r_sh  [HD_LAT];
    logic [H_W-1:0] r_div [HD_LAT];
    logic           r_ovf [HD_LAT];
    logic [H_W-1:0] n_rem [HD_LAT];
    logic [V_W-1:0] n_sh  [HD_LAT];
    logic [H_W-1:0] n_div [HD_LAT];
    logic           n_ovf [HD_LAT];

    always_comb begin
        logic [H_W:0] rs;
        logic         ge;
        // quotient reaching 2^63 means an overflow in some step of the long division
        n_ovf[0] = i_ovf || ({{(CMP_W-V_W){1'b0}}, i_v} >=
                             {{(CMP_W-H_W-OVF_SH){1'b0}}, i_div, {OVF_SH{1'b0}}});
        n_rem[0] = H_W'(i_v[V_W-1:OVF_SH]);
        n_sh[0]  = {i_v[OVF_SH-1:0], {FRAC_BITS{1'b0}}};
        n_div[0] = i_div;
        for (int k = 1; k < HD_LAT; k++) begin
            rs       = {r_rem[k-1], r_sh[k-1][V_W-1]};
            ge       = (rs >= {1'b0, r_div[k-1]});
            n_rem[k] = ge ? H_W'(rs - {1'b0, r_div[k-1]}) : rs[H_W-1:0];
            n_sh[k]  = {r_sh[k-1][V_W-2:0], ge};
            n_div[k] = r_div[k-1];
            n_ovf[k] = r_ovf[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < HD_LAT; k++) begin
                r_rem[k] <= n_rem[k];
                r_sh[k]  <= n_sh[k];
                r_div[k] <= n_div[k];
                r_ovf[k] <= n_ovf[k];
            end
        end
    end

    assign o_v   = r_sh[HD_LAT-1];
    assign o_ovf = r_ovf[HD_LAT-1];

endmodule

/* bench/sph_kernel_eval_checker.sv */
// sph_kernel_eval_checker: watches the offset and result channels of sph_kernel_eval_core,
// predicts every result beat in fixed point and compares it field by field
// depends on ske_pkg
module sph_kernel_eval_checker
    import ske_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_cmd,
    input  logic [31:0] i_dx,
    input  logic [31:0] i_dy,
    input  logic [31:0] i_dz,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [30:0] i_weight,
    input  logic [31:0] i_grad_x,
    input  logic [31:0] i_grad_y,
    input  logic [31:0] i_grad_z,
    input  logic        i_saturated,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [30:0] weight;
        logic [31:0] gx;
        logic [31:0] gy;
        logic [31:0] gz;
        logic        sat;
    } t_kernel_res;

    t_kernel_res kernel_q[$];
    logic        mode_q;
    logic [30:0] radius_q;
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = kernel_q.size();

    function automatic logic [63:0] root64(logic [63:0] x);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= root + b) begin
                x = x - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] ratio64(logic [63:0] a, logic [63:0] b);
        logic [127:0] n;
        n = {a, 64'd0};
        return 64'(n / {64'd0, b});
    endfunction

    function automatic logic [63:0] mulq31(logic [63:0] a, logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 31;
    endfunction

    // all ones flags an overflowed radius division
    function automatic logic [63:0] scale_by_radius(logic [63:0] k, logic [63:0] shape,
                                                     logic [63:0] dir, int n, logic [63:0] hv);
        logic [63:0] v;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] p;
        p = k * mulq31(shape, dir);
        v = p >> 28;
        for (int s = 0; s < n; s++) begin
            quo = v / hv;
            rem = v % hv;
            for (int i = 0; i < FRAC_BITS; i++) begin
                if (quo >= (64'd1 << 62)) return '1;
                quo = quo << 1;
                rem = rem << 1;
                if (rem >= hv) begin
                    rem = rem - hv;
                    quo = quo | 64'd1;
                end
            end
            v = quo;
        end
        return v >> (31 - FRAC_BITS);
    endfunction

    function automatic logic [63:0] unit_dir(logic [63:0] m, logic [63:0] r2);
        logic [63:0] a;
        a = m * m;
        if (a >= r2) return 64'(ONE31);
        return root64(ratio64(a, r2)) >> 1;
    endfunction

    function automatic t_kernel_res eval_kernel(logic cmd, logic [31:0] dx, logic [31:0] dy,
                                                logic [31:0] dz, logic mode,
                                                logic [30:0] radius);
        t_kernel_res res;
        logic [31:0] raw [3];
        logic [63:0] mag [3];
        logic [63:0] r2, hv, h2, uu, qv, uv, om, ou, shape, k, m, one;
        logic        inner, live;
        raw[0] = dx;
        raw[1] = dy;
        raw[2] = dz;
        res = '0;
        one = 64'(ONE31);
        hv = 64'(radius);
        h2 = hv * hv;
        r2 = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = raw[i][31] ? (64'h1_0000_0000 - 64'(raw[i])) : 64'(raw[i]);
            r2 = r2 + mag[i] * mag[i];
        end
        if (r2 < h2) begin
            uu = ratio64(r2, h2);
            qv = root64(uu) >> 1;
            uv = uu >> 33;
            om = one - qv;
            inner = (r2 * 4) <= h2;
            if (!cmd) begin
                if (!mode) begin
                    ou = one - uv;
                    shape = mulq31(mulq31(ou, ou), ou);
                    k = 64'(K_POLY6);
                end else if (inner) begin
                    shape = one - 6 * mulq31(mulq31(qv, qv), om);
                    k = 64'(K_CUB_W);
                end else begin
                    shape = 2 * mulq31(mulq31(om, om), om);
                    k = 64'(K_CUB_W);
                end
                m = scale_by_radius(k, shape, one, 3, hv);
                if (m > 64'(POS_LIM)) begin
                    m = 64'(POS_LIM);
                    res.sat = 1'b1;
                end
                res.weight = m[30:0];
            end else begin
                live = !mode ? (r2 != 0) : (r2 > EPS2_THR);
                if (live) begin
                    if (mode && inner) begin
                        shape = mulq31(qv, 2 * one - 3 * qv);
                        k = 64'(K_CUB_G);
                    end else begin
                        shape = mulq31(om, om);
                        k = mode ? 64'(K_CUB_G) : 64'(K_SPIKY);
                    end
                    for (int i = 0; i < 3; i++) begin
                        if (raw[i] != 0) begin
                            m = scale_by_radius(k, shape, unit_dir(mag[i], r2), 4, hv);
                            if (raw[i][31]) begin
                                if (m > 64'(POS_LIM)) begin
                                    m = 64'(POS_LIM);
                                    res.sat = 1'b1;
                                end
                            end else begin
                                if (m > 64'(NEG_LIM)) begin
                                    m = 64'(NEG_LIM);
                                    res.sat = 1'b1;
                                end
                                m = 64'd0 - m;
                            end
                            case (i)
                                0: res.gx = m[31:0];
                                1: res.gy = m[31:0];
                                default: res.gz = m[31:0];
                            endcase
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_kernel_res want;
        t_kernel_res got;
        if (!i_rst_n) begin
            mode_q   <= 1'b0;
            radius_q <= 31'd65536;
            kernel_q.delete();
            fails    <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_KERNEL_MODE) mode_q <= i_cfg_wdata[0];
                else if (i_cfg_idx == CFG_SMOOTHING_RADIUS) radius_q <= i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready)
                kernel_q.push_back(eval_kernel(i_cmd, i_dx, i_dy, i_dz, mode_q, radius_q));
            if (i_out_valid && i_out_ready) begin
                got = '{i_weight, i_grad_x, i_grad_y, i_grad_z, i_saturated};
                if (kernel_q.size() == 0) begin
                    if (fails < 10) $display("unexpected result beat w=%h", i_weight);
                    fails <= fails + 1;
                end else begin
                    want = kernel_q.pop_front();
                    if (got !== want) begin
                        if (fails < 10)
                            $display("mismatch exp w=%h g=%h %h %h s=%b got w=%h g=%h %h %h s=%b",
                                     want.weight, want.gx, want.gy, want.gz, want.sat,
                                     got.weight, got.gx, got.gy, got.gz, got.sat);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end

endmodule

/* bench/sph_kernel_eval_core_tb.sv */
// sph_kernel_eval_core_tb: drives offset beats and radius/mode settings into
// sph_kernel_eval_core under bursty traffic and back-pressure; checking is done by
// sph_kernel_eval_checker. depends on ske_pkg and the core
module sph_kernel_eval_core_tb;
    import ske_pkg::*;

    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int         DRAIN_CYCLES   = 400;
    localparam int         HOLD_CYCLES    = 1500;
    localparam int         IDLE_LIMIT     = 6000;
    localparam int         PHASES         = 10;
    localparam int         FIRST_RAND     = 500;
    localparam int         RAND_PER_PHASE = 70;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        cmd = 1'b0;
    logic [31:0] dx = '0, dy = '0, dz = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [30:0] weight;
    logic [31:0] grad_x, grad_y, grad_z;
    logic        saturated;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [30:0] cfg_wdata = '0;
    int          fail_count, pending;
    int          burst_left = 0;
    int          out_beats = 0;

    always #2 i_clk = ~i_clk;

    sph_kernel_eval_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_cmd(cmd), .i_dx(dx), .i_dy(dy), .i_dz(dz),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_weight(weight), .o_grad_x(grad_x), .o_grad_y(grad_y), .o_grad_z(grad_z),
        .o_saturated(saturated),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata)
    );

    sph_kernel_eval_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_cmd(cmd), .i_dx(dx), .i_dy(dy), .i_dz(dz),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_weight(weight), .i_grad_x(grad_x), .i_grad_y(grad_y), .i_grad_z(grad_z),
        .i_saturated(saturated),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: stall pattern that changes every window, plus one long hold-off
    // that starts as soon as the first result beat has been taken
    initial begin
        int window, pct;
        bit held;
        held = 0;
        forever begin
            window = $urandom_range(20, 200);
            pct = $urandom_range(0, 3) == 0 ? 100 : $urandom_range(10, 95);
            repeat (window) begin
                @(negedge i_clk);
                if (!held && out_beats > 0) begin
                    held = 1;
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                end
                out_ready <= ($urandom_range(1, 100) <= pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (out_valid && out_ready) out_beats <= out_beats + 1;
    end

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("FAIL sph_kernel_eval_core");
                $finish;
            end
        end
    end

    task automatic send_offset(logic c, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd <= c;
        dx <= x;
        dy <= y;
        dz <= z;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain_all();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] near_comp(logic [30:0] h);
        longint lim;
        lim = longint'(h) >> $urandom_range(0, 3);
        return 32'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
    endfunction

    task automatic send_landmarks(logic [30:0] h);
        logic [31:0] hh, half;
        hh = 32'(h);
        half = hh >> 1;
        for (int c = 0; c < 2; c++) begin
            send_offset(c[0], 32'd0, 32'd0, 32'd0);
            send_offset(c[0], hh, 32'd0, 32'd0);
            send_offset(c[0], half, 32'd0, 32'd0);
            send_offset(c[0], 32'd0, -half, half + 32'd1);
            send_offset(c[0], 32'd1, 32'd0, 32'd0);
            send_offset(c[0], hh - 32'd1, 32'd0, 32'd0);
            send_offset(c[0], 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
            send_offset(c[0], -32'd100, 32'd200, -32'd300);
        end
    endtask

    initial begin
        logic        modes [PHASES];
        logic [30:0] radii [PHASES];
        logic [31:0] x, y, z;
        int          sel;
        modes = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        radii = '{31'd65536, 31'd65536, 31'd1, 31'd1, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  31'd0, 31'(32'($urandom_range(1, 32'h7FFF_FFFF))), 31'h800, 31'h40000};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) drain_all();
            write_reg(CFG_KERNEL_MODE, 31'(modes[p]));
            write_reg(CFG_SMOOTHING_RADIUS, radii[p]);
            if (p == 2) write_reg(CFG_UNUSED_IDX, 31'h1234_5678);
            if (p < 2) send_landmarks(radii[p]);
            for (int n = 0; n < ((p == 0) ? FIRST_RAND : RAND_PER_PHASE); n++) begin
                sel = $urandom_range(0, 9);
                x = near_comp(radii[p]);
                y = near_comp(radii[p]);
                z = near_comp(radii[p]);
                if (sel == 0) begin
                    x = $urandom;
                    y = $urandom;
                    z = $urandom;
                end else if (sel == 1) begin
                    y = '0;
                    if ($urandom_range(0, 1)) z = '0;
                end
                send_offset(1'($urandom_range(0, 1)), x, y, z);
            end
        end
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) $display("PASS sph_kernel_eval_core");
        else $display("FAIL sph_kernel_eval_core");
        $finish;
    end

endmodule
